// File: rtl/itda_pkg.sv
// Shared types and constants for the integer to decimal ASCII converter.
// No dependencies; imported by every module of the block.
package itda_pkg;

  localparam int VALUE_W    = 32;
  localparam int DIGIT_W    = 4;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = DIGIT_W * BCD_DIGITS;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  // One classified number: sign and unsigned magnitude
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } itda_item_t;

  // Fill status of the queue between front and back
  typedef struct packed {
    logic full;
    logic empty;
  } itda_q_status_t;

endpackage

// File: rtl/itda_front.sv
// Front end: splits an incoming signed value into sign and magnitude.
// Depends on itda_pkg.
module itda_front import itda_pkg::*; (
  input  logic signed [VALUE_W-1:0] value,
  output itda_item_t                item
);

  // Negate in unsigned arithmetic so the most negative value maps to 2^31
  always_comb begin
    item.neg = value[VALUE_W-1];
    item.mag = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
  end

endmodule

// File: rtl/itda_queue.sv
// Short FIFO of classified numbers between the front and back ends.
// Depends on itda_pkg.
module itda_queue import itda_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  itda_item_t     push_item,
  input  logic           pop,
  output itda_item_t     head,
  output itda_q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  itda_item_t         entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push_ok;
  logic               pop_ok;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign push_ok      = push && !status.full;
  assign pop_ok       = pop && !status.empty;
  assign head         = entries[rd_ptr];

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (push_ok) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and track fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
        count <= count + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/itda_back.sv
// Back end: shift-add-3 binary to BCD conversion, then character emission
// into a one-entry output register. Depends on itda_pkg.
module itda_back import itda_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  itda_item_t q_head,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] character,
  output logic       last
);

  localparam int STEP_W = $clog2(VALUE_W);
  localparam int DCNT_W = $clog2(BCD_DIGITS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_EMIT
  } state_t;

  state_t               state;
  logic [VALUE_W-1:0]   shift_reg;
  logic [BCD_W-1:0]     bcd;
  logic [BCD_W-1:0]     bcd_adj;
  logic [STEP_W-1:0]    step;
  logic [DCNT_W-1:0]    dcnt;
  logic                 neg_pend;
  logic                 started;
  logic                 out_valid;
  logic                 slot_free;
  logic                 is_last;
  logic [DIGIT_W-1:0]   top_digit;
  logic                 load_char;

  assign empty     = !out_valid;
  assign slot_free = !out_valid || pop;
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign top_digit = bcd[BCD_W-1 -: DIGIT_W];
  assign is_last   = (dcnt == DCNT_W'(BCD_DIGITS - 1));

  // A character enters the output register this cycle
  assign load_char = (state == S_EMIT) && slot_free &&
                     (neg_pend || started || (top_digit != '0) || is_last);

  // Add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && pop && !load_char) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            shift_reg <= q_head.mag;
            neg_pend  <= q_head.neg;
            bcd       <= '0;
            step      <= '0;
            state     <= S_CONV;
          end
        end
        S_CONV: begin
          bcd       <= {bcd_adj[BCD_W-2:0], shift_reg[VALUE_W-1]};
          shift_reg <= {shift_reg[VALUE_W-2:0], 1'b0};
          step      <= step + STEP_W'(1);
          if (step == STEP_W'(VALUE_W - 1)) begin
            dcnt    <= '0;
            started <= 1'b0;
            state   <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (neg_pend) begin
            // Emit the minus sign ahead of the digits
            if (slot_free) begin
              character <= CHAR_MINUS;
              last      <= 1'b0;
              out_valid <= 1'b1;
              neg_pend  <= 1'b0;
            end
          end else if (top_digit == '0 && !started && !is_last) begin
            // Drop a leading zero
            bcd  <= {bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            dcnt <= dcnt + DCNT_W'(1);
          end else if (slot_free) begin
            character <= CHAR_ZERO + {4'b0000, top_digit};
            last      <= is_last;
            out_valid <= 1'b1;
            started   <= 1'b1;
            bcd       <= {bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            dcnt      <= dcnt + DCNT_W'(1);
            if (is_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/int_to_decimal_ascii_core.sv
// Top level of the signed 32-bit integer to decimal ASCII converter.
// Depends on itda_pkg, itda_front, itda_queue and itda_back.
//
// Push a signed 32-bit value; read back its decimal text one ASCII character
// per pop, most significant digit first, with a leading '-' for negative
// values and last set on the final character. Each number is loaded, run
// through the shift-add-3 BCD loop bit by bit, and then its ten BCD digits
// are scanned (leading zeros are dropped one per cycle, digits are emitted one
// per cycle when the reader pops every cycle), after a minus sign if the
// value is negative. Numbers waiting behind the one in conversion are held in a
// QUEUE_DEPTH-entry queue, and full stays low while that queue has room.
module int_to_decimal_ascii_core import itda_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      empty,
  input  logic                      pop,
  output logic [7:0]                character,
  output logic                      last
);

  itda_item_t     front_item;
  itda_item_t     q_head;
  itda_q_status_t q_stat;
  logic           q_pop;

  assign full = q_stat.full;

  // Classify the incoming beat
  itda_front u_front (
    .value (value),
    .item  (front_item)
  );

  // Decouple front from back
  itda_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_stat)
  );

  // Convert and emit characters
  itda_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (!q_stat.empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .character (character),
    .last      (last)
  );

`ifndef ASSERT_OFF
  a_q_status: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty at once");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (character == CHAR_MINUS) ||
               ((character >= CHAR_ZERO) && (character <= CHAR_NINE)))
    else $error("result character outside sign and digit codes");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && (character == CHAR_MINUS)) |-> !last)
    else $error("minus sign marked as last character");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("results pending after reset");
`endif

endmodule

// File: verif/int_to_decimal_ascii_core_tb.sv
// Testbench for int_to_decimal_ascii_core: pushes signed 32-bit values, pops
// their decimal text, and checks each character against a built-in predictor.
// Depends on itda_pkg and the RTL of the converter; nothing else.
module int_to_decimal_ascii_core_tb import itda_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 250;
  localparam int SETTLE_CYCLES  = 60;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      push = 1'b0;
  logic                      full;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      empty;
  logic                      pop = 1'b0;
  logic [7:0]                character;
  logic                      last;

  logic [VALUE_W-1:0] pending_values[$];
  text_char_t         expected_text[$];
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  logic               hold_on = 1'b0;
  int                 hold_count = 0;
  int                 errors = 0;
  int                 quiet_cycles = 0;

  int_to_decimal_ascii_core dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .value     (value),
    .empty     (empty),
    .pop       (pop),
    .character (character),
    .last      (last)
  );

  always #6 clk = ~clk;

  // Append the decimal text of one accepted value to the expected characters
  function automatic void predict_decimal_text(logic [VALUE_W-1:0] raw);
    logic [VALUE_W-1:0] mag;
    logic [3:0]         digits[10];
    int                 n;
    text_char_t         c;
    mag = raw[VALUE_W-1] ? -raw : raw;
    n = 0;
    do begin
      digits[n] = 4'(mag % 10);
      n++;
      mag = mag / 10;
    end while (mag != 0);
    if (raw[VALUE_W-1]) begin
      c.code = CHAR_MINUS;
      c.last = 1'b0;
      expected_text.push_back(c);
    end
    for (int i = n - 1; i >= 0; i--) begin
      c.code = CHAR_ZERO + 8'(digits[i]);
      c.last = (i == 0);
      expected_text.push_back(c);
    end
  endfunction

  // Mix of raw words, tiny values, every digit count and powers of ten +-1
  function automatic logic [VALUE_W-1:0] random_value();
    longint lo;
    longint hi;
    longint mag;
    int     ndig;
    case ($urandom_range(3))
      0: return $urandom;
      1: mag = $urandom_range(20);
      2: begin
        ndig = $urandom_range(10, 1);
        lo = 1;
        repeat (ndig - 1) lo *= 10;
        hi = lo * 10 - 1;
        if (hi > 64'd2147483648) hi = 64'd2147483648;
        mag = lo + ($urandom % (hi - lo + 1));
      end
      default: begin
        lo = 1;
        repeat ($urandom_range(9)) lo *= 10;
        mag = lo + $urandom_range(2) - 1;
      end
    endcase
    if (mag > 64'd2147483647 || $urandom_range(1) == 1) return VALUE_W'(-mag);
    return VALUE_W'(mag);
  endfunction

  // Driver: retire the accepted beat, then offer the next pending value
  always @(posedge clk) begin
    logic offer;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_decimal_text(value);
        void'(pending_values.pop_front());
      end
      offer = (pending_values.size() != 0) && ($urandom_range(99) >= send_idle_pct);
      push <= offer;
      if (offer) begin
        value <= pending_values[0];
      end
    end
  end

  // Monitor: check each popped beat, then decide whether to stall
  always @(posedge clk) begin
    text_char_t exp_c;
    logic       take;
    if (rst) begin
      pop <= 1'b0;
      hold_count <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected character %0d last %0b", $time, character, last);
          errors++;
        end else begin
          exp_c = expected_text.pop_front();
          if (character !== exp_c.code) begin
            $display("%0t: character expected %0d actual %0d", $time, exp_c.code,
                     character);
            errors++;
          end
          if (last !== exp_c.last) begin
            $display("%0t: last expected %0b actual %0b", $time, exp_c.last, last);
            errors++;
          end
        end
      end
      // Hold off for a long stretch while pressure is requested
      if (hold_on && hold_count < LONG_HOLD) begin
        hold_count <= hold_count + 1;
        take = 1'b0;
      end else begin
        if (!hold_on) hold_count <= 0;
        take = ($urandom_range(99) >= recv_stall_pct);
      end
      pop <= take;
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Block the test sequence until every pending value is sent and every expected character has been popped
  task automatic wait_drained();
    while (pending_values.size() != 0 || expected_text.size() != 0) @(negedge clk);
  endtask

  task automatic run_random(int send_pct, int recv_pct, int count);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) pending_values.push_back(random_value());
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: zero, single digits, digit-count edges, both extremes
    send_idle_pct = 0;
    recv_stall_pct = 0;
    pending_values.push_back(32'd0);
    pending_values.push_back(32'd1);
    pending_values.push_back(-32'sd1);
    pending_values.push_back(32'd9);
    pending_values.push_back(32'd10);
    pending_values.push_back(-32'sd10);
    pending_values.push_back(32'd99);
    pending_values.push_back(32'd100);
    pending_values.push_back(32'h7FFF_FFFF);
    pending_values.push_back(32'h8000_0000);
    pending_values.push_back(32'h8000_0001);
    pending_values.push_back(32'd1000000000);
    pending_values.push_back(-32'sd1000000000);
    pending_values.push_back(32'd999999999);
    pending_values.push_back(32'd1999999999);
    pending_values.push_back(32'd123456789);
    pending_values.push_back(32'h5555_5555);
    pending_values.push_back(32'hAAAA_AAAA);
    pending_values.push_back(-32'sd9);
    wait_drained();

    run_random(0, 0, 20);
    run_random(70, 0, 20);
    run_random(0, 70, 20);
    run_random(36, 36, 20);

    // Stall the reader long enough for the block to fill and raise full
    hold_on = 1'b1;
    run_random(0, 0, 20);
    hold_on = 1'b0;

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0 && expected_text.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
